/* rtl/ptcal_pkg.sv */
// shared constants and register codes for the pressure calibrate and average core
package ptcal_pkg;

  // full scale of the second calibration point, in tenths of cmH2O
  localparam int CAL_SCALE = 400;

  // result word width and its saturation limits
  localparam int OUT_W = 16;
  localparam logic [OUT_W-1:0] OUT_MAX = 16'h7FFF;
  localparam logic [OUT_W-1:0] OUT_MIN = 16'h8000;

  // configuration register index
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZERO_POINT = 2'd0,
    CFG_SPAN_POINT = 2'd1
  } cfg_idx_t;

endpackage

/* rtl/pressure_two_point_calibrate_average_core.sv */
// top level of the pressure two-point calibration and moving average core
//
// each beat on the input side carries one raw converter sample; the core turns it into
// tenths of cmH2O as (sample - zero_point) * 400 / (span_point - zero_point), truncated
// toward zero and saturated to 16 bits, then folds it into a ring of WINDOW_LENGTH values
// (zeros after reset) and returns the measured value, the ring mean truncated toward zero,
// the raw sample and a flag that is set when the two calibration points are equal (the
// measured value is then 0 and still enters the ring). the front end takes samples into a
// two-beat queue, so while the result side stalls the core holds two queued samples, one
// finished sample in the back end and one result beat. the back end handles one sample at
// a time: a restoring divider, one quotient bit per cycle, forms the calibration quotient
// and a multiply by the rounded-up reciprocal of WINDOW_LENGTH forms the mean; with equal
// calibration points the divider is skipped. a result beat that is not popped holds the
// back end, and once the queue is full the input too. the user must write the calibration
// registers through the cfg port only while the core is idle; the core itself does not
// enforce this. register index 0 is zero_point, 1 is span_point, other indexes are ignored
module pressure_two_point_calibrate_average_core import ptcal_pkg::*; #(
  parameter int WINDOW_LENGTH = 10,
  parameter int SAMPLE_BITS   = 10
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // sample side
  input  logic                    in_push,
  output logic                    in_full,
  input  logic [SAMPLE_BITS-1:0]  in_adc_sample,
  // result side
  output logic                    out_empty,
  input  logic                    out_pop,
  output logic signed [OUT_W-1:0] out_measured_pressure,
  output logic signed [OUT_W-1:0] out_filtered_pressure,
  output logic [SAMPLE_BITS-1:0]  out_raw_echo,
  output logic                    out_calibration_error,
  // calibration register writes
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [SAMPLE_BITS-1:0]  cfg_data
);

  localparam int Q_DEPTH = 2;

  // one classified sample as it waits between front and back
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] raw;
    logic [SAMPLE_BITS+8:0] num_mag;
    logic                   num_neg;
    logic [SAMPLE_BITS-1:0] dvs_mag;
    logic                   dvs_neg;
    logic                   err;
  } item_t;

  logic [SAMPLE_BITS-1:0] zero_point_r;
  logic [SAMPLE_BITS-1:0] span_point_r;

  item_t q_wr;
  item_t q_rd;
  logic  q_push;
  logic  q_full;
  logic  q_empty;
  logic  q_pop;

  // calibration registers, out-of-range indexes fall through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_point_r <= '0;
      span_point_r <= SAMPLE_BITS'(298);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ZERO_POINT: zero_point_r <= cfg_data;
        CFG_SPAN_POINT: span_point_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // front: accept and scale
  ptcal_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .in_push       (in_push),
    .in_adc_sample (in_adc_sample),
    .in_full       (in_full),
    .zero_point    (zero_point_r),
    .span_point    (span_point_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .raw           (q_wr.raw),
    .num_mag       (q_wr.num_mag),
    .num_neg       (q_wr.num_neg),
    .dvs_mag       (q_wr.dvs_mag),
    .dvs_neg       (q_wr.dvs_neg),
    .err           (q_wr.err)
  );

  // decoupling queue
  ptcal_fifo #(
    .WIDTH (($bits(item_t))),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd),
    .empty   (q_empty)
  );

  // back: divide, average, hold result
  ptcal_back #(
    .WINDOW_LENGTH (WINDOW_LENGTH),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (!q_empty),
    .item_raw     (q_rd.raw),
    .item_num_mag (q_rd.num_mag),
    .item_num_neg (q_rd.num_neg),
    .item_dvs_mag (q_rd.dvs_mag),
    .item_dvs_neg (q_rd.dvs_neg),
    .item_err     (q_rd.err),
    .item_pop     (q_pop),
    .out_pop      (out_pop),
    .out_empty    (out_empty),
    .measured     (out_measured_pressure),
    .filtered     (out_filtered_pressure),
    .raw          (out_raw_echo),
    .err          (out_calibration_error)
  );

  // a flagged calibration always reports zero pressure
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_calibration_error) |-> (out_measured_pressure == '0))
    else $error("calibration error beat with nonzero measured pressure");

  // an accepted sample is waiting in the queue on the next cycle
  a_push_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |=> !q_empty)
    else $error("accepted sample missing from queue");

  // back end never pulls from an empty queue
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("back end popped an empty queue");

endmodule

/* rtl/ptcal_front.sv */
// front end: input handshake, offset removal, scaling and divisor classification
module ptcal_front import ptcal_pkg::*; #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                   in_push,
  input  logic [SAMPLE_BITS-1:0] in_adc_sample,
  output logic                   in_full,
  input  logic [SAMPLE_BITS-1:0] zero_point,
  input  logic [SAMPLE_BITS-1:0] span_point,
  input  logic                   q_full,
  output logic                   q_push,
  output logic [SAMPLE_BITS-1:0] raw,
  output logic [SAMPLE_BITS+8:0] num_mag,
  output logic                   num_neg,
  output logic [SAMPLE_BITS-1:0] dvs_mag,
  output logic                   dvs_neg,
  output logic                   err
);

  localparam int DIF_W = SAMPLE_BITS + 1;
  localparam int NUM_W = SAMPLE_BITS + 10;
  localparam int MAG_W = SAMPLE_BITS + 9;

  logic signed [DIF_W-1:0] sam_dif;
  logic signed [DIF_W-1:0] cal_dif;
  logic signed [NUM_W-1:0] num;
  logic signed [NUM_W-1:0] num_inv;
  logic signed [DIF_W-1:0] cal_inv;

  assign in_full = q_full;
  assign q_push  = in_push && !q_full;
  assign raw     = in_adc_sample;

  assign sam_dif = $signed({1'b0, in_adc_sample}) - $signed({1'b0, zero_point});
  assign cal_dif = $signed({1'b0, span_point}) - $signed({1'b0, zero_point});

  // constant multiply, sign carried separately for the magnitude divider
  assign num     = NUM_W'(sam_dif) * $signed(NUM_W'(CAL_SCALE));
  assign num_inv = -num;
  assign cal_inv = -cal_dif;

  assign num_neg = num[NUM_W-1];
  assign num_mag = num_neg ? MAG_W'($unsigned(num_inv)) : MAG_W'($unsigned(num));
  assign dvs_neg = cal_dif[DIF_W-1];
  assign dvs_mag = dvs_neg ? SAMPLE_BITS'($unsigned(cal_inv))
                           : SAMPLE_BITS'($unsigned(cal_dif));
  assign err     = (cal_dif == '0);

endmodule

/* rtl/ptcal_fifo.sv */
// small first-in first-out queue between front and back end
module ptcal_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

/* rtl/ptcal_back.sv */
// back end: restoring divider, averaging ring, reciprocal mean and result register
module ptcal_back import ptcal_pkg::*; #(
  parameter int WINDOW_LENGTH = 10,
  parameter int SAMPLE_BITS   = 10
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    item_valid,
  input  logic [SAMPLE_BITS-1:0]  item_raw,
  input  logic [SAMPLE_BITS+8:0]  item_num_mag,
  input  logic                    item_num_neg,
  input  logic [SAMPLE_BITS-1:0]  item_dvs_mag,
  input  logic                    item_dvs_neg,
  input  logic                    item_err,
  output logic                    item_pop,
  input  logic                    out_pop,
  output logic                    out_empty,
  output logic signed [OUT_W-1:0] measured,
  output logic signed [OUT_W-1:0] filtered,
  output logic [SAMPLE_BITS-1:0]  raw,
  output logic                    err
);

  localparam int MAG_W  = SAMPLE_BITS + 9;
  localparam int SLOT_W = $clog2(WINDOW_LENGTH);
  localparam int SUM_W  = OUT_W + $clog2(WINDOW_LENGTH);
  localparam int DW     = (MAG_W > SUM_W) ? MAG_W : SUM_W;
  localparam int CNT_W  = $clog2(DW);

  // mean by reciprocal multiply: reciprocal rounded up, exact for any SUM_W-bit magnitude
  localparam int     REC_SH = SUM_W + $clog2(WINDOW_LENGTH);
  localparam int     REC_W  = SUM_W + 1;
  localparam int     PROD_W = SUM_W + REC_W;
  localparam longint REC_M  = ((longint'(1) << REC_SH) + longint'(WINDOW_LENGTH) - 1) /
                              longint'(WINDOW_LENGTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CAL_DIV,
    ST_CAL_FIN,
    ST_UPDATE,
    ST_MEAN_MUL,
    ST_MEAN_FIN
  } state_t;

  state_t                   state_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [DW-1:0]            rem_r;
  logic [DW-1:0]            quo_r;
  logic [DW-1:0]            dvs_r;
  logic                     neg_r;
  logic [SAMPLE_BITS-1:0]   raw_r;
  logic                     err_r;
  logic signed [OUT_W-1:0]  meas_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic [SLOT_W-1:0]        slot_r;
  logic [WINDOW_LENGTH-1:0] valid_r;
  logic signed [OUT_W-1:0]  ring [WINDOW_LENGTH];
  logic signed [OUT_W-1:0]  rd_r;
  logic                     rd_vld_r;
  logic                     out_vld_r;
  logic signed [OUT_W-1:0]  out_meas_r;
  logic signed [OUT_W-1:0]  out_filt_r;
  logic [SAMPLE_BITS-1:0]   out_raw_r;
  logic                     out_err_r;

  logic [DW:0]              trial;
  logic                     trial_ok;
  logic [DW-1:0]            quo_inv;
  logic                     sat_pos;
  logic                     sat_neg;
  logic [OUT_W-1:0]         cal_val;
  logic [OUT_W-1:0]         mean_val;
  logic [PROD_W-1:0]        mean_prod;
  logic signed [OUT_W-1:0]  old_val;
  logic signed [SUM_W-1:0]  sum_upd;
  logic signed [SUM_W-1:0]  sum_inv;
  logic [SUM_W-1:0]         sum_mag;
  logic                     ring_we;
  logic                     last_step;
  logic                     out_load;

  // one quotient bit per cycle
  assign trial     = {rem_r, quo_r[DW-1]} - {1'b0, dvs_r};
  assign trial_ok  = !trial[DW];
  assign last_step = (cnt_r == CNT_W'(DW - 1));

  assign quo_inv  = '0 - quo_r;
  assign sat_pos  = (quo_r > DW'(32767));
  assign sat_neg  = (quo_r > DW'(32768));
  assign cal_val  = neg_r ? (sat_neg ? OUT_MIN : quo_inv[OUT_W-1:0])
                          : (sat_pos ? OUT_MAX : quo_r[OUT_W-1:0]);
  assign mean_val = neg_r ? quo_inv[OUT_W-1:0] : quo_r[OUT_W-1:0];

  // sum magnitude times the reciprocal, quotient taken from the upper bits
  assign mean_prod = PROD_W'(quo_r[SUM_W-1:0]) * PROD_W'(REC_M);

  assign old_val = rd_vld_r ? rd_r : '0;
  assign sum_upd = sum_r - SUM_W'(old_val) + SUM_W'(meas_r);
  assign sum_inv = -sum_upd;
  assign sum_mag = sum_upd[SUM_W-1] ? $unsigned(sum_inv) : $unsigned(sum_upd);

  assign ring_we  = (state_r == ST_UPDATE);
  assign item_pop = (state_r == ST_IDLE) && item_valid;
  assign out_load = (state_r == ST_MEAN_FIN) && (!out_vld_r || out_pop);

  assign out_empty = !out_vld_r;
  assign measured  = out_meas_r;
  assign filtered  = out_filt_r;
  assign raw       = out_raw_r;
  assign err       = out_err_r;

  // ring storage, read data registered
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[slot_r] <= meas_r;
    end
    rd_r <= ring[slot_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      sum_r     <= '0;
      slot_r    <= '0;
      valid_r   <= '0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= valid_r[slot_r];
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_pop) begin
        out_vld_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (item_valid) begin
            raw_r <= item_raw;
            err_r <= item_err;
            rem_r <= '0;
            quo_r <= DW'(item_num_mag);
            dvs_r <= DW'(item_dvs_mag);
            neg_r <= item_num_neg ^ item_dvs_neg;
            cnt_r <= '0;
            if (item_err) begin
              meas_r  <= '0;
              state_r <= ST_UPDATE;
            end else begin
              state_r <= ST_CAL_DIV;
            end
          end
        end
        ST_CAL_DIV: begin
          rem_r <= trial_ok ? trial[DW-1:0] : {rem_r[DW-2:0], quo_r[DW-1]};
          quo_r <= {quo_r[DW-2:0], trial_ok};
          cnt_r <= cnt_r + 1'b1;
          if (last_step) begin
            state_r <= ST_CAL_FIN;
          end
        end
        ST_CAL_FIN: begin
          meas_r  <= $signed(cal_val);
          state_r <= ST_UPDATE;
        end
        ST_UPDATE: begin
          sum_r           <= sum_upd;
          valid_r[slot_r] <= 1'b1;
          slot_r <= (slot_r == SLOT_W'(WINDOW_LENGTH - 1)) ? '0 : slot_r + 1'b1;
          quo_r   <= DW'(sum_mag);
          neg_r   <= sum_upd[SUM_W-1];
          state_r <= ST_MEAN_MUL;
        end
        ST_MEAN_MUL: begin
          quo_r   <= DW'(mean_prod[PROD_W-1:REC_SH]);
          state_r <= ST_MEAN_FIN;
        end
        ST_MEAN_FIN: begin
          if (out_load) begin
            out_meas_r <= meas_r;
            out_filt_r <= $signed(mean_val);
            out_raw_r  <= raw_r;
            out_err_r  <= err_r;
            state_r    <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
